// ----- hw/rtl/sla_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types and constants of the serial line assembler.
// ----------------------------------------------------------------------------
package sla_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int FILL_W       = $clog2(BUFFER_BYTES);
    localparam int WORD_W       = FILL_W - 2;
    localparam int WORDS        = (BUFFER_BYTES + 3) / 4;

    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int IDLE_W       = 16;

    localparam logic [FILL_W-1:0] FILL_MAX   = FILL_W'(BUFFER_BYTES - 1);
    localparam logic [IDLE_W-1:0] IDLE_RESET = IDLE_W'(80);

    localparam logic [PADDR_W-3:0] REG_IDLE_TICKS = '0;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_DEL = 8'd127;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_READY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

endpackage

// ----- hw/rtl/sla_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_if
// Valid/ready channels of the serial line assembler: input items and results.
// ----------------------------------------------------------------------------
interface sla_in_if
    import sla_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface sla_out_if
    import sla_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] line_word;
    logic [2:0]  word_bytes;
    logic        last;
    logic [7:0]  line_length;
    logic [31:0] ready_count;
    logic [31:0] overflow_count;
    logic [31:0] ignored_count;

    modport source (
        output valid, output status, output line_word, output word_bytes,
        output last, output line_length, output ready_count,
        output overflow_count, output ignored_count, input ready
    );
    modport sink (
        input valid, input status, input line_word, input word_bytes,
        input last, input line_length, input ready_count,
        input overflow_count, input ignored_count, output ready
    );
endinterface

// ----- hw/rtl/serial_line_assembler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_assembler_core
// Builds command lines from received bytes and idle ticks.
//
// rx_in carries one item per transfer: a received byte (func 0) or one idle
// tick (func 1). line_out carries results; every result shows the counters
// as they stand after the item that caused it. Items that end no line give
// one result, registered at the accepting edge, and a new item may be taken
// every cycle while line_out keeps up. A CR, LF or idle timeout with stored
// data reads the line back from a 64 x 32-bit store, each word taking a
// memory read and then an output load; rx_in.ready stays low until the last
// word is taken. An overflowed line gives one result.
// When line_out stalls, the output register holds and rx_in.ready drops.
// Reset clears the control state and counters and sets idle_ticks to 80;
// the line store is not cleared and needs no clearing pass.
// The APB port holds idle_ticks at address 0; pready is always high.
// ----------------------------------------------------------------------------
module serial_line_assembler_core
    import sla_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    sla_in_if.sink             rx_in,
    sla_out_if.source          line_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD
    } state_t;

    state_t              state_reg, state_next;
    logic [IDLE_W-1:0]   idle_ticks_reg, idle_ticks_next;
    logic [IDLE_W-1:0]   idle_rem_reg, idle_rem_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                ovf_reg, ovf_next;
    logic [31:0]         lines_done_reg, lines_done_next;
    logic [31:0]         lines_ovf_reg, lines_ovf_next;
    logic [31:0]         ignored_reg, ignored_next;
    logic [7:0]          last_len_reg, last_len_next;
    logic [FILL_W-1:0]   rem_reg, rem_next;
    logic [WORD_W-1:0]   word_idx_reg, word_idx_next;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [31:0]         out_word_reg, out_word_next;
    logic [2:0]          out_nbytes_reg, out_nbytes_next;
    logic                out_last_reg, out_last_next;

    logic [3:0][7:0]     line_mem [WORDS];
    logic [3:0][7:0]     rd_data_reg;
    logic                mem_we;

    logic                accept;
    logic                out_free;
    logic                cfg_we;
    logic [IDLE_W-1:0]   idle_dec;
    logic                line_end;
    logic [2:0]          n_bytes;
    logic                word_last;
    logic [31:0]         masked_word;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite
                    && (paddr[PADDR_W-1:2] == REG_IDLE_TICKS);
    assign prdata = (paddr[PADDR_W-1:2] == REG_IDLE_TICKS)
                    ? PDATA_W'(idle_ticks_reg) : '0;
    assign idle_ticks_next = cfg_we ? pwdata[IDLE_W-1:0] : idle_ticks_reg;

    assign out_free     = !out_valid_reg || line_out.ready;
    assign rx_in.ready  = (state_reg == S_IDLE) && out_free;
    assign accept       = rx_in.valid && rx_in.ready;

    assign idle_dec = (idle_rem_reg != '0) ? idle_rem_reg - 1'b1 : '0;
    assign line_end = (rx_in.func == FUNC_TICK)
                      ? ((idle_dec == '0) && ((fill_reg != '0) || ovf_reg))
                      : ((rx_in.rx_byte == CH_CR) || (rx_in.rx_byte == CH_LF));

    assign n_bytes   = (rem_reg > FILL_W'(4)) ? 3'd4 : rem_reg[2:0];
    assign word_last = (rem_reg <= FILL_W'(4));

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            masked_word[8*i +: 8] = (3'(i) < n_bytes) ? rd_data_reg[i] : 8'h00;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idle_rem_next   = idle_rem_reg;
        fill_next       = fill_reg;
        ovf_next        = ovf_reg;
        lines_done_next = lines_done_reg;
        lines_ovf_next  = lines_ovf_reg;
        ignored_next    = ignored_reg;
        last_len_next   = last_len_reg;
        rem_next        = rem_reg;
        word_idx_next   = word_idx_reg;
        out_valid_next  = out_valid_reg && !line_out.ready;
        out_status_next = out_status_reg;
        out_word_next   = out_word_reg;
        out_nbytes_next = out_nbytes_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_NONE;
                    out_word_next   = '0;
                    out_nbytes_next = '0;
                    out_last_next   = 1'b1;
                    if (line_end)
                    begin
                        if (ovf_reg)
                        begin
                            out_status_next = ST_OVERFLOW;
                            lines_ovf_next  = lines_ovf_reg + 1'b1;
                            fill_next       = '0;
                            ovf_next        = 1'b0;
                            idle_rem_next   = idle_ticks_reg;
                        end
                        else if (fill_reg != '0)
                        begin
                            out_valid_next  = 1'b0;
                            lines_done_next = lines_done_reg + 1'b1;
                            last_len_next   = 8'(fill_reg);
                            rem_next        = fill_reg;
                            word_idx_next   = '0;
                            fill_next       = '0;
                            idle_rem_next   = idle_ticks_reg;
                            state_next      = S_FETCH;
                        end
                    end
                    else if (rx_in.func == FUNC_TICK)
                    begin
                        idle_rem_next = idle_dec;
                    end
                    else if ((rx_in.rx_byte == CH_BS) || (rx_in.rx_byte == CH_DEL))
                    begin
                        if (!ovf_reg && (fill_reg != '0))
                        begin
                            fill_next = fill_reg - 1'b1;
                        end
                        idle_rem_next = idle_ticks_reg;
                    end
                    else if (!(rx_in.rx_byte inside {[8'd32:8'd126]}))
                    begin
                        ignored_next = ignored_reg + 1'b1;
                    end
                    else if (!ovf_reg)
                    begin
                        if (fill_reg >= FILL_MAX)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            mem_we        = 1'b1;
                            fill_next     = fill_reg + 1'b1;
                            idle_rem_next = idle_ticks_reg;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_READY;
                    out_word_next   = masked_word;
                    out_nbytes_next = n_bytes;
                    out_last_next   = word_last;
                    if (word_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rem_next      = rem_reg - FILL_W'(4);
                        word_idx_next = word_idx_reg + 1'b1;
                        state_next    = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idle_ticks_reg <= IDLE_RESET;
            idle_rem_reg   <= IDLE_RESET;
            fill_reg       <= '0;
            ovf_reg        <= 1'b0;
            lines_done_reg <= '0;
            lines_ovf_reg  <= '0;
            ignored_reg    <= '0;
            last_len_reg   <= '0;
            rem_reg        <= '0;
            word_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_NONE;
            out_word_reg   <= '0;
            out_nbytes_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idle_ticks_reg <= idle_ticks_next;
            idle_rem_reg   <= idle_rem_next;
            fill_reg       <= fill_next;
            ovf_reg        <= ovf_next;
            lines_done_reg <= lines_done_next;
            lines_ovf_reg  <= lines_ovf_next;
            ignored_reg    <= ignored_next;
            last_len_reg   <= last_len_next;
            rem_reg        <= rem_next;
            word_idx_reg   <= word_idx_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_word_reg   <= out_word_next;
            out_nbytes_reg <= out_nbytes_next;
            out_last_reg   <= out_last_next;
        end
    end

    // writes happen only in S_IDLE, reads only matter in S_FETCH: no overlap
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[fill_reg[FILL_W-1:2]][fill_reg[1:0]] <= rx_in.rx_byte;
        end
        rd_data_reg <= line_mem[word_idx_reg];
    end

    assign line_out.valid          = out_valid_reg;
    assign line_out.status         = out_status_reg;
    assign line_out.line_word      = out_word_reg;
    assign line_out.word_bytes     = out_nbytes_reg;
    assign line_out.last           = out_last_reg;
    assign line_out.line_length    = last_len_reg;
    assign line_out.ready_count    = lines_done_reg;
    assign line_out.overflow_count = lines_ovf_reg;
    assign line_out.ignored_count  = ignored_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill length beyond buffer");

    a_readout_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (fill_reg == '0) && !ovf_reg)
        else $error("line state not cleared during readout");

    a_word_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_READY))
        |-> (out_nbytes_reg != 3'd0) && (out_nbytes_reg <= 3'd4))
        else $error("ready word with bad byte count");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_READY))
        |-> out_last_reg && (out_nbytes_reg == 3'd0))
        else $error("non-line result not final");

    a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |=> $stable(lines_done_reg) && $stable(ignored_reg))
        else $error("counters moved during readout");
`endif

endmodule

// ----- test/sla_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_checker
// Watches the item channel, the result channel and APB writes of the serial
// line assembler. Each accepted item is run through a line-building predictor,
// and its results are queued. Each result transfer is compared with the
// oldest queued result. Mismatches and unexpected results are counted.
// ----------------------------------------------------------------------------
module sla_checker
    import sla_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    sla_in_if                  rx_mon,
    sla_out_if                 line_mon,
    output int unsigned        outstanding,
    output int unsigned        fail_count
);

    localparam logic [7:0] PRINT_LO   = 8'd32;
    localparam logic [7:0] PRINT_HI   = 8'd126;
    localparam int unsigned MAX_SHOWN = 10;

    typedef struct packed {
        status_t     status;
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
        logic [7:0]  length;
        logic [31:0] lines;
        logic [31:0] overflows;
        logic [31:0] dropped;
    } line_result_t;

    logic [7:0]        line_mem [BUFFER_BYTES];
    int unsigned       fill;
    logic              ovf;
    logic [IDLE_W-1:0] idle_left;
    logic [IDLE_W-1:0] idle_cfg;
    logic [31:0]       done_cnt;
    logic [31:0]       ovf_cnt;
    logic [31:0]       drop_cnt;
    logic [7:0]        last_len;
    line_result_t      expected_q [$];

    function automatic string describe(line_result_t r);
        return $sformatf("st=%0d word=%h bytes=%0d last=%0b len=%0d rdy=%0d ovf=%0d ign=%0d",
                         r.status, r.word, r.nbytes, r.last, r.length,
                         r.lines, r.overflows, r.dropped);
    endfunction

    task automatic queue_result(status_t st, logic [31:0] w, logic [2:0] n, logic l);
        expected_q.push_back('{st, w, n, l, last_len, done_cnt, ovf_cnt, drop_cnt});
    endtask

    task automatic close_line();
        int unsigned len;
        int unsigned words;
        int unsigned nb;
        int unsigned k;
        int unsigned j;
        logic [31:0] w;
        if (ovf) begin
            ovf_cnt++;
            fill      = 0;
            ovf       = 1'b0;
            idle_left = idle_cfg;
            queue_result(ST_OVERFLOW, '0, '0, 1'b1);
        end
        else if (fill == 0) begin
            queue_result(ST_NONE, '0, '0, 1'b1);
        end
        else begin
            len = fill;
            done_cnt++;
            last_len  = 8'(len);
            fill      = 0;
            ovf       = 1'b0;
            idle_left = idle_cfg;
            words     = (len + 3) / 4;
            for (k = 0; k < words; k++) begin
                nb = len - 4 * k;
                if (nb > 4)
                    nb = 4;
                w = '0;
                for (j = 0; j < nb; j++)
                    w[8*j +: 8] = line_mem[4*k + j];
                queue_result(ST_READY, w, 3'(nb), (k + 1 == words));
            end
        end
    endtask

    task automatic predict_item(logic f, logic [7:0] ch);
        if (f == FUNC_TICK) begin
            if (idle_left != 0)
                idle_left--;
            if (idle_left == 0 && (fill > 0 || ovf))
                close_line();
            else
                queue_result(ST_NONE, '0, '0, 1'b1);
        end
        else if (ch == CH_CR || ch == CH_LF) begin
            close_line();
        end
        else begin
            if (ch == CH_BS || ch == CH_DEL) begin
                if (!ovf && fill > 0)
                    fill--;
                idle_left = idle_cfg;
            end
            else if (ch < PRINT_LO || ch > PRINT_HI) begin
                drop_cnt++;
            end
            else if (!ovf) begin
                if (fill >= BUFFER_BYTES - 1) begin
                    ovf = 1'b1;
                end
                else begin
                    line_mem[fill] = ch;
                    fill++;
                    idle_left = idle_cfg;
                end
            end
            queue_result(ST_NONE, '0, '0, 1'b1);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        line_result_t got;
        line_result_t exp;
        if (!rst_n) begin
            fill        = 0;
            ovf         = 1'b0;
            idle_cfg    = IDLE_RESET;
            idle_left   = IDLE_RESET;
            done_cnt    = '0;
            ovf_cnt     = '0;
            drop_cnt    = '0;
            last_len    = '0;
            fail_count  = 0;
            expected_q.delete();
            outstanding <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_IDLE_TICKS)
                idle_cfg = pwdata[IDLE_W-1:0];

            if (line_mon.valid && line_mon.ready) begin
                got = '{status_t'(line_mon.status), line_mon.line_word, line_mon.word_bytes,
                        line_mon.last, line_mon.line_length, line_mon.ready_count,
                        line_mon.overflow_count, line_mon.ignored_count};
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("%t unexpected result: %s", $realtime, describe(got));
                end
                else begin
                    exp = expected_q.pop_front();
                    if (got !== exp) begin
                        fail_count++;
                        if (fail_count <= MAX_SHOWN)
                            $display("%t mismatch\n  exp %s\n  got %s", $realtime,
                                     describe(exp), describe(got));
                    end
                end
            end

            if (rx_mon.valid && rx_mon.ready)
                predict_item(rx_mon.func, rx_mon.rx_byte);

            outstanding <= expected_q.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the serial line assembler with byte and tick transfers under
// several idle_ticks settings and back-pressure modes: a directed opening
// covering edit keys, dropped bytes, line ends and timeouts, random lines,
// then a line that fills the store, overflows and is flushed by timeout.
// Checking is done by sla_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import sla_pkg::*;

    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int unsigned        outstanding;
    int unsigned        fail_count;
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;
    int unsigned        items_sent;
    logic [IDLE_W-1:0]  cur_idle;

    sla_in_if  rx_ch ();
    sla_out_if line_ch ();

    serial_line_assembler_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .rx_in    (rx_ch),
        .line_out (line_ch)
    );

    sla_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .rx_mon      (rx_ch),
        .line_mon    (line_ch),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        line_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic apb_write(logic [PADDR_W-3:0] idx, logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_idle = val[IDLE_W-1:0];
    endtask

    task automatic push_item(logic f, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.func    <= f;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        items_sent++;
    endtask

    task automatic settle();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reconfigure(logic [IDLE_W-1:0] ticks, int unsigned s_pct, int unsigned r_pct);
        settle();
        apb_write(REG_IDLE_TICKS, PDATA_W'(ticks));
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
    endtask

    task automatic push_printables(int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            push_item(FUNC_BYTE, 8'($urandom_range(PRINT_LO, PRINT_HI)));
    endtask

    task automatic push_noise();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while ((b >= PRINT_LO && b <= PRINT_HI) || b == CH_BS || b == CH_DEL ||
               b == CH_CR || b == CH_LF);
        push_item(FUNC_BYTE, b);
    endtask

    task automatic push_line();
        int unsigned len;
        int unsigned pick;
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        for (int unsigned k = 0; k < len; k++) begin
            pick = $urandom_range(99);
            if (pick < 80)
                push_printables(1);
            else if (pick < 88)
                push_item(FUNC_BYTE, $urandom_range(1) ? CH_BS : CH_DEL);
            else if (pick < 94)
                push_noise();
            else if (pick < 97)
                push_item(FUNC_TICK, 8'($urandom));
            else
                push_item(FUNC_BYTE, 8'($urandom));
        end
        pick = $urandom_range(99);
        if (pick < 40)
            push_item(FUNC_BYTE, CH_CR);
        else if (pick < 75 || cur_idle > 16)
            push_item(FUNC_BYTE, CH_LF);
        else
            repeat (cur_idle + 1) push_item(FUNC_TICK, 8'($urandom));
    endtask

    task automatic random_lines(int unsigned n);
        int unsigned stop;
        stop = items_sent + n;
        while (items_sent < stop)
            push_line();
    endtask

    initial
    begin
        #10_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.func    = FUNC_BYTE;
        rx_ch.rx_byte = '0;
        line_ch.ready = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 65;
        items_sent    = 0;
        cur_idle      = IDLE_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening, short timeout
        apb_write(REG_IDLE_TICKS, 2);
        push_item(FUNC_BYTE, PRINT_LO);
        push_item(FUNC_BYTE, PRINT_HI);
        push_item(FUNC_BYTE, "A");
        push_item(FUNC_BYTE, CH_BS);
        push_item(FUNC_BYTE, "B");
        push_item(FUNC_BYTE, CH_DEL);
        push_item(FUNC_BYTE, "C");
        push_item(FUNC_BYTE, "D");
        push_item(FUNC_BYTE, "E");
        push_item(FUNC_BYTE, 8'd31);
        push_item(FUNC_BYTE, 8'd128);
        push_item(FUNC_BYTE, 8'd255);
        push_item(FUNC_BYTE, 8'd0);
        push_item(FUNC_BYTE, CH_CR);
        push_item(FUNC_BYTE, CH_LF);
        push_item(FUNC_BYTE, CH_BS);
        push_item(FUNC_TICK, 8'hFF);
        push_item(FUNC_TICK, 8'h00);
        push_item(FUNC_BYTE, "x");
        push_item(FUNC_TICK, 8'h5A);
        push_item(FUNC_TICK, 8'hA5);
        push_item(FUNC_BYTE, "y");
        push_item(FUNC_BYTE, "z");
        push_item(FUNC_TICK, 8'h00);
        push_item(FUNC_BYTE, "w");
        push_item(FUNC_TICK, 8'h00);
        push_item(FUNC_TICK, 8'h00);

        reconfigure(16'd1, 21, 65);
        random_lines(30);

        // longest timeout
        reconfigure(16'hFFFF, 65, 21);
        random_lines(20);

        // zero timeout: first tick with pending data flushes
        reconfigure(16'd0, 65, 21);
        random_lines(20);

        // store filled, overflow, edit while overflowed, flushed by timeout
        reconfigure(16'd4, 0, 0);
        push_printables(BUFFER_BYTES);
        push_item(FUNC_BYTE, CH_DEL);
        repeat (5) push_item(FUNC_TICK, 8'($urandom));

        settle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
